// ===== rtl/oca_pkg.sv =====
// Package for the OHLCV candle aggregator: transaction payload types,
// register map codes and window length helpers. No dependencies.
package oca_pkg;

  localparam int unsigned TimeW     = 40;
  localparam int unsigned PriceW    = 32;
  localparam int unsigned VolW      = 32;
  localparam int unsigned VolSumW   = 48;
  localparam int unsigned MinutesW  = 6;
  localparam int unsigned WinSecsW  = 12;
  localparam int unsigned PaddrW    = 3;
  localparam int unsigned PdataW    = 32;

  localparam logic [MinutesW-1:0] MinMinutes     = 6'd5;
  localparam logic [MinutesW-1:0] MaxMinutes     = 6'd60;
  localparam logic [MinutesW-1:0] MinutesReset   = 6'd5;
  localparam logic [WinSecsW-1:0] SecsPerMin     = 12'd60;

  typedef enum logic [0:0] {
    RegCandleMinutes = 1'b0
  } reg_idx_e;

  typedef struct packed {
    logic [TimeW-1:0]  quote_time;
    logic [PriceW-1:0] quote_price;
    logic [VolW-1:0]   quote_volume;
  } quote_t;

  typedef struct packed {
    logic [TimeW-1:0]    candle_time;
    logic [PriceW-1:0]   open_price;
    logic [PriceW-1:0]   high_price;
    logic [PriceW-1:0]   low_price;
    logic [PriceW-1:0]   close_price;
    logic [VolSumW-1:0]  volume_total;
  } candle_t;

  function automatic logic [WinSecsW-1:0] window_secs(input logic [MinutesW-1:0] minutes);
    logic [MinutesW-1:0] m;
    m = minutes;
    if (m < MinMinutes) m = MinMinutes;
    if (m > MaxMinutes) m = MaxMinutes;
    return WinSecsW'(m) * SecsPerMin;
  endfunction

endpackage

// ===== rtl/oca_if.sv =====
// Valid/ready stream interfaces for quotes in and candles out.
// Depends on oca_pkg for the payload types.
interface oca_quote_if;
  import oca_pkg::*;
  logic   valid;
  logic   ready;
  quote_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface oca_candle_if;
  import oca_pkg::*;
  logic    valid;
  logic    ready;
  candle_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/oca_window.sv =====
// Window state of the candle aggregator: open/high/low/volume holds and
// the boundary decision for one quote per cycle. Depends on oca_pkg.
module oca_window
  import oca_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                advance_i,
  input  quote_t              quote_i,
  input  logic [MinutesW-1:0] minutes_i,
  output logic                emit_o,
  output candle_t             candle_o
);

  logic                started_q, started_d;
  logic                fresh_q, fresh_d;
  logic [TimeW-1:0]    start_q, start_d;
  logic [PriceW-1:0]   open_q, open_d;
  logic [PriceW-1:0]   high_q, high_d;
  logic [PriceW-1:0]   low_q, low_d;
  logic [VolSumW-1:0]  vol_q, vol_d;

  logic [TimeW-1:0]    ws;
  logic [TimeW:0]      win_end;
  logic                in_window;
  logic                base_fresh;
  logic [PriceW-1:0]   base_open, base_high, base_low;
  logic [VolSumW-1:0]  base_vol;
  logic [VolSumW:0]    vol_sum;

  always_comb begin
    ws        = started_q ? start_q : quote_i.quote_time;
    win_end   = {1'b0, ws} + (TimeW+1)'(window_secs(minutes_i));
    in_window = win_end > {1'b0, quote_i.quote_time};
    emit_o    = !in_window;

    candle_o.candle_time  = ws;
    candle_o.open_price   = open_q;
    candle_o.high_price   = high_q;
    candle_o.low_price    = low_q;
    candle_o.close_price  = quote_i.quote_price;
    candle_o.volume_total = vol_q;

    base_fresh = in_window ? fresh_q : 1'b1;
    base_open  = in_window ? open_q  : '0;
    base_high  = in_window ? high_q  : '0;
    base_low   = in_window ? low_q   : '1;
    base_vol   = in_window ? vol_q   : '0;

    open_d  = base_fresh ? quote_i.quote_price : base_open;
    high_d  = (quote_i.quote_price > base_high) ? quote_i.quote_price : base_high;
    low_d   = (quote_i.quote_price < base_low) ? quote_i.quote_price : base_low;
    vol_sum = {1'b0, base_vol} + (VolSumW+1)'(quote_i.quote_volume);
    vol_d   = vol_sum[VolSumW] ? '1 : vol_sum[VolSumW-1:0];
    fresh_d   = 1'b0;
    started_d = 1'b1;
    start_d   = in_window ? ws : quote_i.quote_time;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      fresh_q   <= 1'b1;
      start_q   <= '0;
      open_q    <= '0;
      high_q    <= '0;
      low_q     <= '1;
      vol_q     <= '0;
    end else if (advance_i) begin
      started_q <= started_d;
      fresh_q   <= fresh_d;
      start_q   <= start_d;
      open_q    <= open_d;
      high_q    <= high_d;
      low_q     <= low_d;
      vol_q     <= vol_d;
    end
  end

  a_started_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    started_q |=> started_q)
    else $error("window started flag dropped");

  a_high_ge_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fresh_q |-> high_q >= low_q)
    else $error("high hold below low hold");

endmodule

// ===== rtl/ohlcv_candle_aggregator_top.sv =====
// OHLCV candle aggregator. Takes one quote transaction per cycle; a quote at
// or past the window end yields one candle, held in an output register. Throughput
// is one quote per cycle, set by the single update stage between the quote register
// and the candle register; a waiting candle stalls the input only while the quote
// register is also full. Window length is written through the APB port at address 0.
// Depends on oca_pkg, oca_if, oca_window.
module ohlcv_candle_aggregator_top
  import oca_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  oca_quote_if.sink         quote_i,
  oca_candle_if.source      candle_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready
);

  logic [MinutesW-1:0] minutes_q;
  logic                in_valid_q;
  quote_t              in_q;
  logic                out_valid_q, out_valid_d;
  candle_t             out_q;
  logic                advance;
  logic                emit;
  candle_t             candle;
  logic                wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign prdata = (reg_idx_e'(paddr[2]) == RegCandleMinutes) ?
                  PdataW'(minutes_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      minutes_q <= MinutesReset;
    end else if (wr_en) begin
      unique case (reg_idx_e'(paddr[2]))
        RegCandleMinutes: minutes_q <= pwdata[MinutesW-1:0];
        default: ;
      endcase
    end
  end

  assign advance       = in_valid_q && (!out_valid_q || candle_o.ready);
  assign quote_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (quote_i.ready) begin
      in_valid_q <= quote_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (quote_i.valid && quote_i.ready) in_q <= quote_i.payload;
  end

  oca_window u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .quote_i   (in_q),
    .minutes_i (minutes_q),
    .emit_o    (emit),
    .candle_o  (candle)
  );

  always_comb begin
    if (advance && emit) out_valid_d = 1'b1;
    else if (candle_o.ready) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else out_valid_q <= out_valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) out_q <= candle;
  end

  assign candle_o.valid   = out_valid_q;
  assign candle_o.payload = out_q;

  a_stalled_quote_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && !candle_o.ready |=> in_valid_q)
    else $error("stalled quote lost");

  a_emit_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && emit |=> out_valid_q)
    else $error("candle not registered");

  a_ready_when_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> quote_i.ready)
    else $error("input stalled with empty output");

endmodule

// ===== dv/ohlcv_candle_aggregator_top_tb.sv =====
`timescale 1ns / 100ps
// Testbench for ohlcv_candle_aggregator_top: drives quote transactions and APB writes,
// predicts candles in a scoreboard class and checks each candle field by field.
// Depends on oca_pkg, oca_if and the aggregator RTL.
module ohlcv_candle_aggregator_top_tb;
  import oca_pkg::*;

  localparam logic [PaddrW-1:0]  MinutesAddr  = PaddrW'(4 * int'(RegCandleMinutes));
  localparam logic [PaddrW-1:0]  UnmappedAddr = PaddrW'(4 * (int'(RegCandleMinutes) + 1));
  localparam logic [TimeW-1:0]   TimeTop      = '1;
  localparam logic [PriceW-1:0]  PriceTop     = '1;
  localparam logic [VolW-1:0]    VolTop       = '1;
  localparam logic [VolSumW-1:0] VolSumTop    = '1;

  class candle_tracker;
    candle_t             pending_candles[$];
    int unsigned         failures;
    logic [MinutesW-1:0] minutes;
    logic [TimeW-1:0]    win_start;
    bit                  seen_any;
    bit                  awaiting_open;
    logic [PriceW-1:0]   first_px;
    logic [PriceW-1:0]   top_px;
    logic [PriceW-1:0]   bottom_px;
    logic [VolSumW-1:0]  vol_acc;

    function new();
      failures  = 0;
      minutes   = MinutesReset;
      win_start = '0;
      seen_any  = 1'b0;
      clear_window();
    endfunction

    function void clear_window();
      first_px      = '0;
      top_px        = '0;
      bottom_px     = '1;
      vol_acc       = '0;
      awaiting_open = 1'b1;
    endfunction

    function void write_reg(logic [PaddrW-1:0] addr, logic [PdataW-1:0] data);
      if (addr == MinutesAddr) minutes = data[MinutesW-1:0];
    endfunction

    function logic [63:0] window_len();
      logic [63:0] m;
      m = 64'(minutes);
      if (m < 64'(MinMinutes)) m = 64'(MinMinutes);
      if (m > 64'(MaxMinutes)) m = 64'(MaxMinutes);
      return m * 64'(SecsPerMin);
    endfunction

    function void note_quote(quote_t q);
      candle_t     c;
      logic [63:0] sum;
      if (!seen_any) begin
        seen_any  = 1'b1;
        win_start = q.quote_time;
      end
      if (64'(win_start) + window_len() <= 64'(q.quote_time)) begin
        c.candle_time  = win_start;
        c.open_price   = first_px;
        c.high_price   = top_px;
        c.low_price    = bottom_px;
        c.close_price  = q.quote_price;
        c.volume_total = vol_acc;
        pending_candles = {pending_candles, c};
        win_start = q.quote_time;
        clear_window();
      end
      if (awaiting_open) begin
        first_px      = q.quote_price;
        awaiting_open = 1'b0;
      end
      if (q.quote_price > top_px) top_px = q.quote_price;
      if (q.quote_price < bottom_px) bottom_px = q.quote_price;
      sum = 64'(vol_acc) + 64'(q.quote_volume);
      vol_acc = (sum > 64'(VolSumTop)) ? VolSumTop : sum[VolSumW-1:0];
    endfunction

    function void compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
        failures++;
      end
    endfunction

    function void check_candle(candle_t got);
      candle_t want;
      if (pending_candles.size() == 0) begin
        $error("unexpected candle at time %0h", got.candle_time);
        failures++;
        return;
      end
      want = pending_candles[0];
      pending_candles.delete(0);
      compare_field("candle_time", 64'(want.candle_time), 64'(got.candle_time));
      compare_field("open_price", 64'(want.open_price), 64'(got.open_price));
      compare_field("high_price", 64'(want.high_price), 64'(got.high_price));
      compare_field("low_price", 64'(want.low_price), 64'(got.low_price));
      compare_field("close_price", 64'(want.close_price), 64'(got.close_price));
      compare_field("volume_total", 64'(want.volume_total), 64'(got.volume_total));
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [PdataW-1:0] pwdata;
  logic [PdataW-1:0] prdata;
  logic              pready;

  oca_quote_if  quote_bus ();
  oca_candle_if candle_bus ();

  candle_tracker book;
  int unsigned   idle_pct = 20;
  logic [63:0]   now_s;

  ohlcv_candle_aggregator_top uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .quote_i  (quote_bus),
    .candle_o (candle_bus),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    candle_bus.ready <= ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && candle_bus.valid && candle_bus.ready) book.check_candle(candle_bus.payload);
  end

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // called at a falling edge; returns at the falling edge after acceptance, valid still high
  task automatic push_quote(input logic [TimeW-1:0] t, input logic [PriceW-1:0] p,
                            input logic [VolW-1:0] v);
    quote_t q;
    q.quote_time   = t;
    q.quote_price  = p;
    q.quote_volume = v;
    while ($urandom_range(99) < idle_pct) begin
      quote_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    quote_bus.valid   <= 1'b1;
    quote_bus.payload <= q;
    do @(posedge clk_i); while (!quote_bus.ready);
    book.note_quote(q);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    quote_bus.valid <= 1'b0;
    while (book.pending_candles.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic apb_write(input logic [PaddrW-1:0] addr, input logic [PdataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    book.write_reg(addr, data);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [TimeW-1:0] pick_time();
    logic [63:0] span;
    int unsigned r;
    span = book.window_len();
    r = $urandom_range(99);
    if (r < 15) return TimeW'(now_s);
    if (r < 20) return TimeW'(now_s - 64'($urandom_range(0, 700)));
    if (r < 30) now_s += span + 64'($urandom_range(0, 32'(span)));
    else if (r < 32) now_s += 64'($urandom_range(0, 32'hFF_FFFF));
    else now_s += 64'($urandom_range(0, 32'(span / 4)));
    return TimeW'(now_s);
  endfunction

  function automatic logic [PriceW-1:0] pick_price();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 20) return PriceTop;
    return $urandom;
  endfunction

  function automatic logic [VolW-1:0] pick_volume();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 20) return VolTop;
    return $urandom;
  endfunction

  initial begin
    logic [PdataW-1:0] cfg;
    book               = new();
    rst_ni             = 1'b0;
    quote_bus.valid    = 1'b0;
    quote_bus.payload  = '0;
    candle_bus.ready   = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // default 5 minute window
    push_quote(40'd0, 32'd1000, 32'd0);
    push_quote(40'd100, 32'd0, VolTop);
    push_quote(40'd200, PriceTop, 32'd1);
    push_quote(40'd50, 32'd5000, 32'd7);
    push_quote(40'd299, 32'd1234, 32'd10);
    push_quote(40'd300, 32'd777, 32'd3);
    push_quote(40'd300, 32'd888, 32'd5);
    push_quote(40'd5000, 32'd42, 32'd1);
    push_quote(40'd5299, 32'd43, 32'd1);
    push_quote(40'd5600, 32'd44, 32'd1);
    wait_drained();
    apb_write(MinutesAddr, 32'd0);
    push_quote(40'd5899, 32'd1, 32'd1);
    push_quote(40'd5900, 32'd2, 32'd2);
    wait_drained();
    apb_write(MinutesAddr, 32'd60);
    push_quote(40'd9499, 32'd3, 32'd3);
    push_quote(40'd9500, 32'd4, 32'd4);
    wait_drained();
    apb_write(MinutesAddr, 32'd63);
    apb_write(UnmappedAddr, 32'd1);
    push_quote(40'd13099, 32'd5, 32'd5);
    push_quote(40'd13100, 32'd6, 32'd6);
    now_s = 64'd13100;

    // one window of full-volume trades, back to back
    wait_drained();
    apb_write(MinutesAddr, 32'd5);
    idle_pct = 0;
    now_s += 64'd1000;
    repeat (60) push_quote(TimeW'(now_s), pick_price(), VolTop);
    now_s += 64'd300;
    push_quote(TimeW'(now_s), pick_price(), pick_volume());
    idle_pct = 20;

    for (int ph = 0; ph < 8; ph++) begin
      wait_drained();
      case (ph)
        0: cfg = 32'd60;
        1: cfg = 32'd5;
        2: cfg = 32'hFFFF_FFFF;
        3: cfg = 32'd0;
        default: cfg = $urandom;
      endcase
      apb_write(MinutesAddr, cfg);
      idle_pct = (ph == 4) ? 0 : 20;
      if ($urandom_range(3) == 0) now_s += {28'd0, 4'($urandom_range(0, 15)), 32'($urandom)};
      for (int n = 0; n < 140; n++) begin
        if (n == 70) wait_drained();
        push_quote(pick_time(), pick_price(), pick_volume());
      end
    end

    // top of the timestamp range
    wait_drained();
    idle_pct = 20;
    apb_write(MinutesAddr, 32'd5);
    push_quote(TimeTop - 40'd400, pick_price(), pick_volume());
    push_quote(TimeTop - 40'd100, pick_price(), pick_volume());
    push_quote(TimeTop, PriceTop, VolTop);
    push_quote(40'd0, 32'd0, 32'd0);
    push_quote(TimeTop, pick_price(), pick_volume());
    wait_drained();

    if (book.failures == 0 && book.pending_candles.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
